FILE: hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranging block.
package uer_pkg;

    localparam int TRIG_W    = 10;
    localparam int TIMEOUT_W = 20;
    localparam int SCALE_W   = 16;
    localparam int DIST_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int QDEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_COEFF   = 2'd2;

    localparam logic [TRIG_W-1:0]    TRIG_RESET    = 10'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd10000;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 16'd11151;

    localparam logic [DIST_W-1:0]    DIST_MAX      = 16'hFFFF;

    // Per-tick status that travels from the sequencer to the scaling pipeline.
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic no_response;
        logic first;
    } uer_flags_t;

    localparam int FLAGS_W = $bits(uer_flags_t);

endpackage

FILE: hdl/ultrasonic_echo_ranging.sv
// Top level of the ultrasonic echo ranging controller.
//
//  port group  | dir | handshake          | content
//  s_*         | in  | s_valid / s_ready  | one microsecond tick: start_req, first_time, echo
//  m_*         | out | m_valid / m_ready  | one status item per tick, distances in mm
//  cfg_*       | in  | cfg_wr_en          | trig_ticks, timeout_ticks, scale_coeff by index
//
// One item per cycle sustained while m_ready is held high; each accepted item passes through
// the queue register, the product register and the output register.
// The tick sequencer updates its state only on an accepted item; the scaling side
// drains the queue on its own, so a stalled output fills the four-entry queue
// before s_ready drops. Reset is synchronous and clears all control state.
module ultrasonic_echo_ranging #(
    parameter int TIMER_BITS   = 20,
    parameter int SMOOTH_SHIFT = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_start_req,
    input  logic                            s_first_time,
    input  logic                            s_echo,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_trig,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic                            m_no_response,
    output logic [uer_pkg::DIST_W-1:0]      m_raw_distance_mm,
    output logic [uer_pkg::DIST_W-1:0]      m_avg_distance_mm,
    input  logic                            cfg_wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
    import uer_pkg::*;

    localparam int EW = FLAGS_W + TIMER_BITS;

    logic [TRIG_W-1:0]    trig_ticks_reg;
    logic [TIMEOUT_W-1:0] timeout_ticks_reg;
    logic [SCALE_W-1:0]   scale_coeff_reg;

    logic                  in_fire;
    uer_flags_t            f_flags, q_flags;
    logic [TIMER_BITS-1:0] f_width, q_width;
    logic [EW-1:0]         q_rd_data;
    logic                  q_valid, q_pop;

    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ticks_reg    <= TRIG_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
            scale_coeff_reg   <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TRIG_TICKS:    trig_ticks_reg    <= cfg_wdata[TRIG_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[TIMEOUT_W-1:0];
                REG_SCALE_COEFF:   scale_coeff_reg   <= cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uer_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .s_start_req   (s_start_req),
        .s_first_time  (s_first_time),
        .s_echo        (s_echo),
        .trig_ticks    (trig_ticks_reg),
        .timeout_ticks (timeout_ticks_reg),
        .flags         (f_flags),
        .meas_width    (f_width)
    );

    uer_queue #(
        .WIDTH (EW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .wr_data   ({f_flags, f_width}),
        .in_ready  (s_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .rd_data   (q_rd_data)
    );

    assign q_flags = q_rd_data[EW-1:TIMER_BITS];
    assign q_width = q_rd_data[TIMER_BITS-1:0];

    uer_back #(
        .TIMER_BITS   (TIMER_BITS),
        .SMOOTH_SHIFT (SMOOTH_SHIFT)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_flags           (q_flags),
        .q_width           (q_width),
        .q_pop             (q_pop),
        .scale_coeff       (scale_coeff_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_trig            (m_trig),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_no_response     (m_no_response),
        .m_raw_distance_mm (m_raw_distance_mm),
        .m_avg_distance_mm (m_avg_distance_mm)
    );

endmodule

FILE: hdl/uer_front.sv
// Tick sequencer: trigger pulse, timeout window and echo edge timing.
module uer_front #(
    parameter int TIMER_BITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_fire,
    input  logic                        s_start_req,
    input  logic                        s_first_time,
    input  logic                        s_echo,
    input  logic [uer_pkg::TRIG_W-1:0]    trig_ticks,
    input  logic [uer_pkg::TIMEOUT_W-1:0] timeout_ticks,
    output uer_pkg::uer_flags_t         flags,
    output logic [TIMER_BITS-1:0]       meas_width
);
    import uer_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_TRIG = 3'b010,
        PH_WAIT = 3'b100
    } phase_t;

    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [TIMER_BITS-1:0] width_reg, width_next;
    logic                  rise_reg, rise_next;
    logic                  first_reg, first_next;
    logic                  echo_prev_reg;

    logic [TRIG_W-1:0]    tt;
    logic [TIMEOUT_W-1:0] to;
    logic                 edge_rise, edge_fall;

    assign tt        = (trig_ticks == '0) ? TRIG_W'(1) : trig_ticks;
    assign to        = (timeout_ticks == '0) ? TIMEOUT_W'(1) : timeout_ticks;
    assign edge_rise = s_echo & ~echo_prev_reg;
    assign edge_fall = ~s_echo & echo_prev_reg;

    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        width_next = width_reg;
        rise_next  = rise_reg;
        first_next = first_reg;
        flags      = '0;
        meas_width = width_reg;

        case (phase_reg)
            PH_TRIG, PH_WAIT: begin
            end
            default: begin
                phase_next = PH_IDLE;
                if (s_start_req) begin
                    phase_next = PH_TRIG;
                    timer_next = '0;
                    width_next = '0;
                    rise_next  = 1'b0;
                    first_next = s_first_time;
                end
            end
        endcase

        case (phase_next)
            PH_TRIG: begin
                flags.busy = 1'b1;
                flags.trig = 1'b1;
                if (timer_next != TMAX) timer_next = timer_next + 1'b1;
                if ((32'(timer_next) >= 32'(tt)) || (timer_next == TMAX)) begin
                    phase_next = PH_WAIT;
                    timer_next = '0;
                end
            end
            PH_WAIT: begin
                flags.busy = 1'b1;
                if (timer_next != TMAX) timer_next = timer_next + 1'b1;
                if (rise_reg && (width_next != TMAX)) width_next = width_next + 1'b1;
                if (edge_rise) begin
                    rise_next  = 1'b1;
                    width_next = '0;
                end else if (edge_fall && rise_reg) begin
                    flags.done = 1'b1;
                    meas_width = width_next;
                    phase_next = PH_IDLE;
                end
                // a falling edge on the timeout tick still counts as a measurement
                if (!flags.done &&
                    ((32'(timer_next) >= 32'(to)) || (timer_next == TMAX))) begin
                    flags.done        = 1'b1;
                    flags.no_response = 1'b1;
                    phase_next        = PH_IDLE;
                end
                if (flags.done) begin
                    rise_next  = 1'b0;
                    timer_next = '0;
                end
            end
            default: begin
            end
        endcase

        flags.first = first_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            width_reg     <= '0;
            rise_reg      <= 1'b0;
            first_reg     <= 1'b0;
            echo_prev_reg <= 1'b0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            width_reg     <= width_next;
            rise_reg      <= rise_next;
            first_reg     <= first_next;
            echo_prev_reg <= s_echo;
        end
    end

endmodule

FILE: hdl/uer_queue.sv
// Short FIFO between the tick sequencer and the scaling pipeline.
module uer_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             in_ready,
    input  logic             pop,
    output logic             out_valid,
    output logic [WIDTH-1:0] rd_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;

    assign in_ready  = (count_reg != FULLC);
    assign out_valid = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULLC)
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> out_valid)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> in_ready)
        else $error("push into full queue");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

FILE: hdl/uer_back.sv
// Scaling pipeline: width to millimetres, saturation and running average.
module uer_back #(
    parameter int TIMER_BITS   = 20,
    parameter int SMOOTH_SHIFT = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  uer_pkg::uer_flags_t          q_flags,
    input  logic [TIMER_BITS-1:0]        q_width,
    output logic                         q_pop,
    input  logic [uer_pkg::SCALE_W-1:0]  scale_coeff,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_trig,
    output logic                         m_busy_res,
    output logic                         m_done_res,
    output logic                         m_no_response,
    output logic [uer_pkg::DIST_W-1:0]   m_raw_distance_mm,
    output logic [uer_pkg::DIST_W-1:0]   m_avg_distance_mm
);
    import uer_pkg::*;

    localparam int PW = TIMER_BITS + SCALE_W;
    localparam int SW = DIST_W + SMOOTH_SHIFT + 1;

    logic             s1_valid_reg;
    uer_flags_t       s1_flags_reg;
    logic [PW-1:0]    s1_prod_reg;
    logic             s2_load;
    logic             success;
    logic [31:0]      scaled;
    logic [DIST_W-1:0] raw;
    logic [SW-1:0]    acc;
    logic [DIST_W-1:0] avg_next;
    logic [DIST_W-1:0] smooth_reg;
    logic             m_valid_reg;

    assign s2_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop   = q_valid && (!s1_valid_reg || s2_load);
    assign m_valid = m_valid_reg;

    // stage 1: register the product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (q_pop) begin
            s1_valid_reg <= 1'b1;
        end else if (s2_load) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_flags_reg <= q_flags;
            s1_prod_reg  <= PW'(q_width) * PW'(scale_coeff);
        end
    end

    // stage 2: saturate, then load or blend the average
    assign success = s1_flags_reg.done && !s1_flags_reg.no_response;
    assign scaled  = 32'(s1_prod_reg >> SCALE_W);
    assign raw     = (scaled > 32'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
    assign acc     = (SW'(smooth_reg) << SMOOTH_SHIFT) - SW'(smooth_reg) + SW'(raw);

    always_comb begin
        avg_next = smooth_reg;
        if (success) begin
            avg_next = s1_flags_reg.first ? raw : DIST_W'(acc >> SMOOTH_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            smooth_reg  <= '0;
        end else begin
            if (s2_load) begin
                m_valid_reg <= 1'b1;
                smooth_reg  <= avg_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            m_trig            <= s1_flags_reg.trig;
            m_busy_res        <= s1_flags_reg.busy;
            m_done_res        <= s1_flags_reg.done;
            m_no_response     <= s1_flags_reg.no_response;
            m_raw_distance_mm <= success ? raw : '0;
            m_avg_distance_mm <= avg_next;
        end
    end

    a_avg_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_avg_distance_mm == smooth_reg))
        else $error("output average differs from running average");

    a_raw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !(m_done_res && !m_no_response)) |-> (m_raw_distance_mm == '0))
        else $error("raw distance without a measurement");

    a_nores_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_response) |-> (m_done_res && m_busy_res))
        else $error("no_response without done");

    a_avg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s2_load |=> $stable(smooth_reg))
        else $error("average moved without an item");

endmodule

FILE: dv/echo_ranging_checker.sv
// Checker for the ranging block: predicts every tick status item and compares results.
`timescale 1ns / 1ps

module echo_ranging_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_start_req,
    input  logic                                s_first_time,
    input  logic                                s_echo,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_trig,
    input  logic                                m_busy_res,
    input  logic                                m_done_res,
    input  logic                                m_no_response,
    input  logic [uer_pkg::DIST_W-1:0]          m_raw_distance_mm,
    input  logic [uer_pkg::DIST_W-1:0]          m_avg_distance_mm,
    input  logic                                cfg_wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [uer_pkg::CFG_DAT_W-1:0]       cfg_wdata,
    output int                                  fail_count,
    output int                                  pending
);
    import uer_pkg::*;

    localparam int TIMER_W      = 20;
    localparam int SMOOTH_SHIFT = 6;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [23:0] SMOOTH_WEIGHT = 24'((1 << SMOOTH_SHIFT) - 1);

    typedef enum logic [1:0] {
        PING_IDLE = 2'd0,
        PING_TRIG = 2'd1,
        PING_WAIT = 2'd2
    } ping_phase_t;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic              no_resp;
        logic [DIST_W-1:0] raw;
        logic [DIST_W-1:0] avg;
    } tick_status_t;

    // register shadows
    logic [TRIG_W-1:0]    trig_len;
    logic [TIMEOUT_W-1:0] window_len;
    logic [SCALE_W-1:0]   mm_per_tick;

    // sensor sequencer shadow
    ping_phase_t          ph;
    logic [TIMER_W-1:0]   tick_cnt;
    logic [TIMER_W-1:0]   pulse_len;
    logic                 armed;
    logic                 echo_last;
    logic                 load_direct;
    logic [DIST_W-1:0]    avg_mm;

    tick_status_t         expected_ticks[$];
    int                   errors;

    function automatic logic [TIMER_W-1:0] bump(logic [TIMER_W-1:0] v);
        return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

    task advance_tick(input logic st, input logic ft, input logic ec, output tick_status_t r);
        logic [TIMER_W-1:0] trig_end;
        logic [TIMER_W-1:0] win_end;
        logic [35:0]        prod;
        logic [23:0]        acc;
        logic               rise;
        logic               fall;
        r = '0;
        trig_end = TIMER_W'(trig_len);
        win_end = TIMER_W'(window_len);
        // a zero length counts as one tick
        if (trig_end == '0) trig_end = TIMER_W'(1);
        if (win_end == '0) win_end = TIMER_W'(1);
        if (ph != PING_TRIG && ph != PING_WAIT) begin
            ph = PING_IDLE;
            if (st) begin
                ph = PING_TRIG;
                tick_cnt = '0;
                pulse_len = '0;
                armed = 1'b0;
                load_direct = ft;
            end
        end
        if (ph == PING_TRIG) begin
            r.trig = 1'b1;
            r.busy = 1'b1;
            tick_cnt = bump(tick_cnt);
            if (tick_cnt >= trig_end || tick_cnt == TIMER_MAX) begin
                ph = PING_WAIT;
                tick_cnt = '0;
            end
        end else if (ph == PING_WAIT) begin
            rise = ec && !echo_last;
            fall = !ec && echo_last;
            r.busy = 1'b1;
            tick_cnt = bump(tick_cnt);
            if (armed) pulse_len = bump(pulse_len);
            if (rise) begin
                armed = 1'b1;
                pulse_len = '0;
            end else if (fall && armed) begin
                prod = {16'd0, pulse_len} * {20'd0, mm_per_tick};
                r.raw = (|prod[35:32]) ? DIST_MAX : prod[31:16];
                acc = {8'd0, avg_mm} * SMOOTH_WEIGHT + {8'd0, r.raw};
                avg_mm = load_direct ? r.raw : acc[SMOOTH_SHIFT +: DIST_W];
                r.done = 1'b1;
                ph = PING_IDLE;
            end
            // a fall on the last window tick still counts as a measurement
            if (!r.done && (tick_cnt >= win_end || tick_cnt == TIMER_MAX)) begin
                r.done = 1'b1;
                r.no_resp = 1'b1;
                ph = PING_IDLE;
            end
            if (r.done) begin
                armed = 1'b0;
                tick_cnt = '0;
            end
        end
        echo_last = ec;
        r.avg = avg_mm;
    endtask

    task report_field(input string what, input logic [DIST_W-1:0] want,
                      input logic [DIST_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : score
        tick_status_t want;
        tick_status_t got;
        if (!aresetn) begin
            trig_len = TRIG_RESET;
            window_len = TIMEOUT_RESET;
            mm_per_tick = SCALE_RESET;
            ph = PING_IDLE;
            tick_cnt = '0;
            pulse_len = '0;
            armed = 1'b0;
            echo_last = 1'b0;
            load_direct = 1'b0;
            avg_mm = '0;
            expected_ticks.delete();
            errors = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TRIG_TICKS:    trig_len = cfg_wdata[TRIG_W-1:0];
                    REG_TIMEOUT_TICKS: window_len = cfg_wdata[TIMEOUT_W-1:0];
                    REG_SCALE_COEFF:   mm_per_tick = cfg_wdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_trig, m_busy_res, m_done_res, m_no_response,
                       m_raw_distance_mm, m_avg_distance_mm};
                if (expected_ticks.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got);
                end else begin
                    want = expected_ticks.pop_front();
                    report_field("trig", DIST_W'(want.trig), DIST_W'(got.trig));
                    report_field("busy", DIST_W'(want.busy), DIST_W'(got.busy));
                    report_field("done", DIST_W'(want.done), DIST_W'(got.done));
                    report_field("no_response", DIST_W'(want.no_resp), DIST_W'(got.no_resp));
                    report_field("raw_distance_mm", want.raw, got.raw);
                    report_field("avg_distance_mm", want.avg, got.avg);
                end
            end
            if (s_valid && s_ready) begin
                advance_tick(s_start_req, s_first_time, s_echo, want);
                expected_ticks.push_back(want);
            end
        end
        pending <= expected_ticks.size();
        fail_count <= errors;
    end

endmodule

FILE: dv/tb_top.sv
// Top of the ranging testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
    import uer_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_TICKS = 950;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_start_req;
    logic                 s_first_time;
    logic                 s_echo;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_trig;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic                 m_no_response;
    logic [DIST_W-1:0]    m_raw_distance_mm;
    logic [DIST_W-1:0]    m_avg_distance_mm;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int ticks_sent = 0;
    int quiet_cycles = 0;
    int hold_reqs = 0;
    int hold_dones = 0;
    int cur_trig = 10;
    int cur_win = 10000;
    bit idle_en = 1'b0;

    ultrasonic_echo_ranging u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_req       (s_start_req),
        .s_first_time      (s_first_time),
        .s_echo            (s_echo),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_trig            (m_trig),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_no_response     (m_no_response),
        .m_raw_distance_mm (m_raw_distance_mm),
        .m_avg_distance_mm (m_avg_distance_mm),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    echo_ranging_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_req       (s_start_req),
        .s_first_time      (s_first_time),
        .s_echo            (s_echo),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_trig            (m_trig),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_no_response     (m_no_response),
        .m_raw_distance_mm (m_raw_distance_mm),
        .m_avg_distance_mm (m_avg_distance_mm),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    always begin
        aclk = 1'b1;
        #HALF_PERIOD;
        aclk = 1'b0;
        #HALF_PERIOD;
    end

    // watchdog: end the run if no item moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall bursts plus a requested long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_reqs != hold_dones) begin
                hold_dones++;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_ranging(input logic [TRIG_W-1:0] trig, input logic [TIMEOUT_W-1:0] win,
                               input logic [SCALE_W-1:0] scale);
        write_reg(REG_TRIG_TICKS, CFG_DAT_W'(trig));
        write_reg(REG_TIMEOUT_TICKS, CFG_DAT_W'(win));
        write_reg(REG_SCALE_COEFF, CFG_DAT_W'(scale));
        cur_trig = (trig == '0) ? 1 : int'(trig);
        cur_win = (win == '0) ? 1 : int'(win);
    endtask

    task automatic put_tick(input logic st, input logic ft, input logic ec);
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 9) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_start_req = st;
        s_first_time = ft;
        s_echo = ec;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
    endtask

    // one measurement: trigger ticks, low lead-in, echo pulse of span ticks, falling edge
    task automatic ping(input logic ld_first, input int lead, input int span, input logic noisy);
        int k;
        put_tick(1'b1, ld_first, noisy ? 1'($urandom_range(0, 1)) : 1'b0);
        for (k = 1; k < cur_trig; k++) begin
            put_tick($urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
                     noisy ? 1'($urandom_range(0, 1)) : 1'b0);
        end
        repeat (lead) put_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0);
        repeat (span) put_tick(1'b0, 1'($urandom_range(0, 1)), 1'b1);
        // now and then land a start on the done tick; it must be dropped
        put_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : stimulus
        int phase_no;
        int n;
        s_valid = 1'b0;
        s_start_req = 1'b0;
        s_first_time = 1'b0;
        s_echo = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero lengths act as one tick; a start on the timeout tick is dropped
        write_reg(REG_SPARE, CFG_DAT_W'($urandom_range(0, 1048575)));
        set_ranging('0, '0, 16'hFFFF);
        put_tick(1'b1, 1'b1, 1'b0);
        put_tick(1'b1, 1'b0, 1'b0);
        // echo already high in the trigger, then falls with no rise before it
        put_tick(1'b1, 1'b0, 1'b1);
        put_tick(1'b0, 1'b1, 1'b0);
        settle();
        set_ranging(10'd1, 20'd4, 16'hFFFF);
        // fall on the last window tick wins over the timeout
        put_tick(1'b1, 1'b1, 1'b0);
        put_tick(1'b0, 1'b0, 1'b1);
        put_tick(1'b0, 1'b1, 1'b1);
        put_tick(1'b0, 1'b0, 1'b1);
        put_tick(1'b1, 1'b1, 1'b0);
        // echo held high into the window gives no rising edge
        put_tick(1'b1, 1'b0, 1'b1);
        put_tick(1'b0, 1'b0, 1'b1);
        put_tick(1'b0, 1'b1, 1'b1);
        put_tick(1'b0, 1'b0, 1'b0);
        put_tick(1'b0, 1'b1, 1'b0);
        // short pulse averaged into the running distance
        put_tick(1'b1, 1'b0, 1'b0);
        put_tick(1'b0, 1'b0, 1'b1);
        put_tick(1'b0, 1'b0, 1'b0);
        settle();

        phase_no = 0;
        while (ticks_sent < RANDOM_TICKS) begin
            idle_en = ($urandom_range(0, 3) != 0);
            if (phase_no == 1) begin
                // keep offering items through a long result stall
                idle_en = 1'b0;
                hold_reqs++;
            end
            case (phase_no % 4)
                0: set_ranging(TRIG_RESET, TIMEOUT_RESET, SCALE_RESET);
                1: set_ranging(TRIG_W'($urandom_range(1, 12)),
                               TIMEOUT_W'($urandom_range(10, 100)), '0);
                default: set_ranging(TRIG_W'($urandom_range(1, 12)),
                                     TIMEOUT_W'($urandom_range(10, 100)),
                                     SCALE_W'($urandom_range(0, 65535)));
            endcase
            n = $urandom_range(2, 4);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(5, 30)) begin
                        put_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    end
                end else begin
                    ping($urandom_range(0, 3) == 0, $urandom_range(0, 12),
                         $urandom_range(0, (cur_win < 90) ? cur_win : 90),
                         1'($urandom_range(0, 1)));
                end
            end
            settle();
            phase_no++;
        end

        // no idling from here on: long trigger, then a one-tick window
        idle_en = 1'b0;
        set_ranging(10'd40, 20'd1, SCALE_W'($urandom_range(0, 65535)));
        ping(1'b1, 0, 0, 1'b1);
        settle();

        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
